@@ hw/rtl/cedc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cedc_pkg: shared types and constants of the channel entry display controller
// Digit encoding, key and command codes, register indexes and segment lookup.
// ----------------------------------------------------------------------------
package cedc_pkg;

    typedef logic [3:0] digit_t;
    typedef logic [1:0] scan_t;
    typedef logic [1:0] position_t;
    typedef logic [0:0] cfg_index_t;

    localparam int ENTRY_TIMEOUT_W = 10;
    localparam int SLEEP_TIMEOUT_W = 12;
    localparam int CFG_DATA_W      = 12;
    localparam int SEG_W           = 8;
    localparam int SELECT_W        = 3;

    localparam digit_t DIGIT_BLANK = 4'd10;
    localparam digit_t DIGIT_MAX   = 4'd9;
    localparam digit_t DIGIT_ZERO  = 4'd0;

    localparam digit_t KEY_PREV = 4'd11;
    localparam digit_t KEY_NEXT = 4'd12;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    localparam cfg_index_t CFG_ENTRY_TIMEOUT = 1'b0;
    localparam cfg_index_t CFG_SLEEP_TIMEOUT = 1'b1;

    localparam logic [ENTRY_TIMEOUT_W-1:0] ENTRY_TIMEOUT_RST = 10'd500;
    localparam logic [SLEEP_TIMEOUT_W-1:0] SLEEP_TIMEOUT_RST = 12'd2500;

    localparam scan_t     SCAN_UNITS    = 2'd0;
    localparam scan_t     SCAN_TENS     = 2'd1;
    localparam scan_t     SCAN_LAST     = 2'd2;
    localparam position_t POS_FIRST     = 2'd0;
    localparam position_t POS_SECOND    = 2'd1;
    localparam position_t POS_LAST      = 2'd2;

    typedef struct packed {
        digit_t hundreds;
        digit_t tens;
        digit_t units;
    } number_t;

    localparam number_t NUMBER_RST = '{hundreds: 4'd3, tens: 4'd2, units: 4'd1};

    // Edit request from the control path to the digit datapath
    typedef struct packed {
        logic      step_next;
        logic      step_prev;
        logic      enter;
        digit_t    key;
        position_t position;
    } digit_ctrl_t;

    // Seven-segment pattern, active high; blank and invalid codes are dark
    function automatic logic [SEG_W-1:0] seg_code(input digit_t d);
        logic [SEG_W-1:0] code;
        begin
            unique case (d)
                4'd0:    code = 8'h3F;
                4'd1:    code = 8'h06;
                4'd2:    code = 8'h5B;
                4'd3:    code = 8'h4F;
                4'd4:    code = 8'h66;
                4'd5:    code = 8'h6D;
                4'd6:    code = 8'h7D;
                4'd7:    code = 8'h07;
                4'd8:    code = 8'h7F;
                4'd9:    code = 8'h67;
                default: code = 8'h00;
            endcase
            return code;
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/channel_entry_display_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// channel_entry_display_controller: channel number entry and display scan
// Edits a three-digit channel number from key transactions and scans it onto
// a multiplexed seven-segment display on tick transactions, with entry and
// inactivity timeouts.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Signals                        | Payload
//  --------+-----------+--------------------------------+---------------------------
//  s_      | in        | s_tvalid s_tready s_tdata/user | key_code; cmd in tuser
//  m_      | out       | m_tvalid m_tready m_tdata/user | select, segments, digits
//  cfg_    | in        | cfg_we cfg_index cfg_data      | entry / sleep timeouts
//
//  One transaction per clock in sustained flow while m_tready stays high. A
//  transaction waits in the input register until the result register is free,
//  then its result is loaded there. The state update between them sets the rate.
//  Reset (rst_n low, asynchronous) loads channel 321 on display, timeouts of
//  500 and 2500 ticks, and empties both registers. A stalled m_ side holds the
//  result and the input register; s_tready drops only when both are full.
//
module channel_entry_display_controller (
    input  wire         clk,
    input  wire         rst_n,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [3:0] key_code, [7:4] zero
    input  wire         s_tuser,   // [0] cmd
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [2:0] digit_select, [10:3] segment_drive,
                                   // [14:11] units, [18:15] tens,
                                   // [22:19] hundreds, [23] zero
    output logic        m_tuser,   // [0] asleep
    // Configuration write port
    input  wire                                cfg_we,
    input  wire  cedc_pkg::cfg_index_t         cfg_index,
    input  wire  [cedc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cedc_pkg::*;

    // Configuration
    logic [ENTRY_TIMEOUT_W-1:0] entry_timeout_reg;
    logic [SLEEP_TIMEOUT_W-1:0] sleep_timeout_reg;

    // Input register
    logic   in_valid_reg;
    logic   in_cmd_reg;
    digit_t in_key_reg;

    // Block state
    number_t                    number_reg;
    number_t                    number_next;
    position_t                  entry_pos_reg;
    position_t                  entry_pos_next;
    logic [ENTRY_TIMEOUT_W-1:0] entry_timer_reg;
    logic [ENTRY_TIMEOUT_W-1:0] entry_timer_next;
    logic [SLEEP_TIMEOUT_W-1:0] idle_timer_reg;
    logic [SLEEP_TIMEOUT_W-1:0] idle_timer_next;
    scan_t                      scan_reg;
    scan_t                      scan_next;
    logic                       sleep_reg;
    logic                       sleep_next;
    logic [SEG_W-1:0]           shown_reg;
    logic [SEG_W-1:0]           shown_next;

    // Result register
    logic                out_valid_reg;
    logic [SELECT_W-1:0] out_select_reg;
    logic [SEG_W-1:0]    out_segment_reg;
    logic                out_asleep_reg;
    number_t             out_number_reg;

    // Control
    logic                     pipe_free;
    logic                     advance;
    logic                     in_accept;
    logic                     is_key;
    logic                     is_tick;
    logic                     key_is_digit;
    digit_ctrl_t              digit_ctrl;
    logic [ENTRY_TIMEOUT_W:0] entry_timer_inc;
    logic [SLEEP_TIMEOUT_W-1:0] idle_after_entry;
    scan_t                    scan_step;
    digit_t                   scan_digit;

    // Result register is free when empty or being drained this cycle
    assign pipe_free = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && pipe_free;
    assign s_tready  = !in_valid_reg || pipe_free;
    assign in_accept = s_tvalid && s_tready;

    assign is_key       = in_cmd_reg == CMD_KEY;
    assign is_tick      = (in_cmd_reg == CMD_TICK) && !sleep_reg;
    assign key_is_digit = in_key_reg <= DIGIT_MAX;

    assign digit_ctrl.step_next = is_key && (in_key_reg == KEY_NEXT);
    assign digit_ctrl.step_prev = is_key && (in_key_reg == KEY_PREV);
    assign digit_ctrl.enter     = is_key && key_is_digit;
    assign digit_ctrl.key       = in_key_reg;
    assign digit_ctrl.position  = entry_pos_reg;

    cedc_digits u_digits (
        .number      (number_reg),
        .ctrl        (digit_ctrl),
        .number_next (number_next)
    );

    assign entry_timer_inc = {1'b0, entry_timer_reg} + (ENTRY_TIMEOUT_W+1)'(1);

    // Scan position after a tick: units, tens, hundreds, then back to units
    assign scan_step = (scan_reg >= SCAN_LAST) ? SCAN_UNITS : scan_reg + 2'd1;

    // Digit shown after the scan advances; an unused index reads the hundreds
    always_comb
    begin
        case (scan_step)
            SCAN_UNITS: scan_digit = number_reg.units;
            SCAN_TENS:  scan_digit = number_reg.tens;
            default:    scan_digit = number_reg.hundreds;
        endcase
    end

    always_comb
    begin
        entry_pos_next   = entry_pos_reg;
        entry_timer_next = entry_timer_reg;
        idle_timer_next  = idle_timer_reg;
        scan_next        = scan_reg;
        sleep_next       = sleep_reg;
        shown_next       = shown_reg;
        idle_after_entry = idle_timer_reg;

        if (is_key)
        begin
            // Any key wakes the block before it acts
            if (sleep_reg)
            begin
                sleep_next      = 1'b0;
                scan_next       = SCAN_UNITS;
                idle_timer_next = SLEEP_TIMEOUT_W'(1);
            end
            if (digit_ctrl.step_next || digit_ctrl.step_prev)
            begin
                idle_timer_next = SLEEP_TIMEOUT_W'(1);
            end
            if (digit_ctrl.enter)
            begin
                idle_timer_next = SLEEP_TIMEOUT_W'(1);
                if (entry_pos_reg >= POS_LAST)
                begin
                    entry_pos_next   = POS_FIRST;
                    entry_timer_next = '0;
                end
                else
                begin
                    entry_pos_next   = entry_pos_reg + 2'd1;
                    entry_timer_next = ENTRY_TIMEOUT_W'(1);
                end
            end
        end
        else if (is_tick)
        begin
            scan_next  = scan_step;
            shown_next = ~seg_code(scan_digit);

            // Close a running entry on timeout and restart inactivity count
            if (entry_timer_reg != '0)
            begin
                if (entry_timer_inc >= {1'b0, entry_timeout_reg})
                begin
                    entry_timer_next = '0;
                    entry_pos_next   = POS_FIRST;
                    idle_after_entry = SLEEP_TIMEOUT_W'(1);
                end
                else
                begin
                    entry_timer_next = entry_timer_inc[ENTRY_TIMEOUT_W-1:0];
                end
            end

            if (idle_after_entry != '0)
            begin
                if (idle_after_entry >= sleep_timeout_reg)
                begin
                    sleep_next      = 1'b1;
                    idle_timer_next = '0;
                    shown_next      = '0;
                end
                else
                begin
                    idle_timer_next = idle_after_entry + SLEEP_TIMEOUT_W'(1);
                end
            end
            else
            begin
                idle_timer_next = idle_after_entry;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_timeout_reg <= ENTRY_TIMEOUT_RST;
            sleep_timeout_reg <= SLEEP_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENTRY_TIMEOUT: entry_timeout_reg <= cfg_data[ENTRY_TIMEOUT_W-1:0];
                CFG_SLEEP_TIMEOUT: sleep_timeout_reg <= cfg_data[SLEEP_TIMEOUT_W-1:0];
            endcase
        end
    end

    // Input register: load on accept, drop once the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_cmd_reg <= s_tuser;
            in_key_reg <= s_tdata[3:0];
        end
    end

    // Block state advances once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_reg      <= NUMBER_RST;
            entry_pos_reg   <= POS_FIRST;
            entry_timer_reg <= '0;
            idle_timer_reg  <= SLEEP_TIMEOUT_W'(1);
            scan_reg        <= SCAN_UNITS;
            sleep_reg       <= 1'b0;
            shown_reg       <= '0;
        end
        else if (advance)
        begin
            number_reg      <= number_next;
            entry_pos_reg   <= entry_pos_next;
            entry_timer_reg <= entry_timer_next;
            idle_timer_reg  <= idle_timer_next;
            scan_reg        <= scan_next;
            sleep_reg       <= sleep_next;
            shown_reg       <= shown_next;
        end
    end

    // Result register: fill on advance, empty when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_select_reg  <= sleep_next ? '0 : SELECT_W'(3'b001 << scan_next);
            out_segment_reg <= sleep_next ? '0 : shown_next;
            out_asleep_reg  <= sleep_next;
            out_number_reg  <= number_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_asleep_reg;
    assign m_tdata  = {1'b0, out_number_reg.hundreds, out_number_reg.tens,
                       out_number_reg.units, out_segment_reg, out_select_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Inactivity timer is stopped exactly while asleep
    a_idle_matches_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        (idle_timer_reg == '0) == sleep_reg)
        else $error("idle timer and sleep flag disagree");

    // Digits stay within 0..9 or blank
    a_digits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (number_reg.units <= DIGIT_BLANK) && (number_reg.tens <= DIGIT_BLANK) &&
        (number_reg.hundreds <= DIGIT_BLANK))
        else $error("channel digit out of range");

    // Entry position and scan never reach the unused code
    a_pos_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_pos_reg <= POS_LAST) && (scan_reg <= SCAN_LAST))
        else $error("entry position or scan index out of range");

    // An awake result selects exactly one digit; an asleep one drives nothing
    a_select_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_asleep_reg ? (out_select_reg == '0 && out_segment_reg == '0)
                                          : $onehot(out_select_reg)))
        else $error("digit select does not match sleep state");

    // A tick while asleep leaves the block state untouched
    a_sleep_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && sleep_reg && (in_cmd_reg == CMD_TICK)) |=>
            ($stable(number_reg) && $stable(scan_reg) && sleep_reg))
        else $error("state changed on a tick while asleep");

endmodule
`default_nettype wire

@@ hw/rtl/cedc_digits.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cedc_digits: decimal edit of the three-digit channel number
// Next/previous with saturation and right-to-left digit entry.
// ----------------------------------------------------------------------------
module cedc_digits (
    input  wire  cedc_pkg::number_t     number,
    input  wire  cedc_pkg::digit_ctrl_t ctrl,
    output cedc_pkg::number_t           number_next
);
    import cedc_pkg::*;

    logic [4:0] units_inc;
    logic [4:0] tens_inc;
    logic [4:0] hundreds_inc;
    logic       carry_units;
    logic       carry_tens;
    logic       carry_hundreds;
    logic       borrow_units;
    logic       borrow_tens;
    logic       borrow_hundreds;
    number_t    inc_number;
    number_t    dec_number;
    number_t    entry_number;

    // Blank counts as ten in the carry chain
    assign units_inc    = {1'b0, number.units} + 5'd1;
    assign tens_inc     = {1'b0, number.tens} + 5'd1;
    assign hundreds_inc = {1'b0, number.hundreds} + 5'd1;

    assign carry_units    = units_inc > {1'b0, DIGIT_MAX};
    assign carry_tens     = carry_units && (tens_inc > {1'b0, DIGIT_MAX});
    assign carry_hundreds = carry_tens && (hundreds_inc > {1'b0, DIGIT_MAX});

    assign borrow_units    = number.units == DIGIT_ZERO;
    assign borrow_tens     = borrow_units && (number.tens == DIGIT_ZERO);
    assign borrow_hundreds = borrow_tens && (number.hundreds == DIGIT_ZERO);

    always_comb
    begin
        inc_number = number;
        inc_number.units = carry_units ? DIGIT_ZERO : units_inc[3:0];
        if (carry_units)
        begin
            inc_number.tens = carry_tens ? DIGIT_ZERO : tens_inc[3:0];
        end
        if (carry_tens)
        begin
            inc_number.hundreds = hundreds_inc[3:0];
        end
        // Saturate at 999
        if (carry_hundreds)
        begin
            inc_number = '{hundreds: DIGIT_MAX, tens: DIGIT_MAX, units: DIGIT_MAX};
        end
    end

    always_comb
    begin
        dec_number = number;
        dec_number.units = borrow_units ? DIGIT_MAX : number.units - 4'd1;
        if (borrow_units)
        begin
            dec_number.tens = borrow_tens ? DIGIT_MAX : number.tens - 4'd1;
        end
        if (borrow_tens)
        begin
            dec_number.hundreds = number.hundreds - 4'd1;
        end
        // Saturate at 000
        if (borrow_hundreds)
        begin
            dec_number = '{hundreds: DIGIT_ZERO, tens: DIGIT_ZERO, units: DIGIT_ZERO};
        end
    end

    always_comb
    begin
        case (ctrl.position)
            POS_FIRST:
            begin
                entry_number = '{hundreds: DIGIT_BLANK, tens: DIGIT_BLANK, units: ctrl.key};
            end
            POS_SECOND:
            begin
                entry_number = '{hundreds: number.hundreds, tens: number.units,
                                 units: ctrl.key};
            end
            default:
            begin
                entry_number = '{hundreds: number.tens, tens: number.units, units: ctrl.key};
            end
        endcase
    end

    always_comb
    begin
        priority if (ctrl.step_next)
        begin
            number_next = inc_number;
        end
        else if (ctrl.step_prev)
        begin
            number_next = dec_number;
        end
        else if (ctrl.enter)
        begin
            number_next = entry_number;
        end
        else
        begin
            number_next = number;
        end
    end

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level testbench for the channel entry display controller
// A queue-fed driver offers tick and key transactions at the falling edge.
// A shadow model of the digits, entry and sleep timers predicts one display
// transaction per input. A monitor compares each display transaction against
// the oldest prediction. Timeouts are rewritten between phases, and the
// idle and stall patterns change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
    import cedc_pkg::*;

    // Input transaction: cmd travels on tuser, key_code in tdata[3:0]
    typedef struct packed {
        logic   cmd;
        digit_t key;
    } key_item_t;

    // Display transaction, unpacked from m_tdata / m_tuser
    typedef struct packed {
        logic              asleep;
        digit_t            hundreds;
        digit_t            tens;
        digit_t            units;
        logic [SEG_W-1:0]  segs;
        logic [SELECT_W-1:0] select;
    } display_t;

    // Active-high glyphs for 0..9 and blank (index 10)
    localparam logic [10:0][7:0] GLYPHS = {
        8'h00, 8'h67, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };
    // Key codes the block leaves alone while awake
    localparam logic [15:0] SPARE_KEYS  = {4'd15, 4'd14, 4'd13, 4'd10};
    localparam int          STALL_LEN   = 120;
    localparam int          MAX_REPORTS = 20;
    localparam int          SETTLE      = 4;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = CMD_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic                  cfg_we    = 1'b0;
    cfg_index_t            cfg_index = CFG_ENTRY_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    channel_entry_display_controller DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow state of the controller
    // ------------------------------------------------------------------
    digit_t                     sh_units, sh_tens, sh_hundreds;
    position_t                  sh_pos;
    logic [ENTRY_TIMEOUT_W-1:0] sh_entry_ticks;   // 0 = stopped
    logic [SLEEP_TIMEOUT_W-1:0] sh_idle_ticks;    // 0 = stopped
    scan_t                      sh_scan;
    logic                       sh_asleep;
    logic [SEG_W-1:0]           sh_segs;
    logic [ENTRY_TIMEOUT_W-1:0] sh_entry_limit;
    logic [SLEEP_TIMEOUT_W-1:0] sh_sleep_limit;

    key_item_t pending[$];        // items waiting for the driver
    display_t  expected_disp[$];  // predicted display transactions, oldest first

    int  errors        = 0;
    int  items_taken   = 0;
    int  results_seen  = 0;
    int  sleeps_seen   = 0;
    int  entries_timed = 0;
    int  wakes_seen    = 0;
    int  send_gap_pct  = 0;
    int  recv_gap_pct  = 0;
    int  tick_burst_max = 8;
    logic s_taken      = 1'b0;
    logic stall_phase  = 1'b0;
    int   stall_cycles = 0;
    key_item_t next_item;

    function automatic logic [SEG_W-1:0] glyph_of(input digit_t d);
        return (d <= DIGIT_BLANK) ? GLYPHS[d] : '0;
    endfunction

    function automatic digit_t digit_at(input scan_t idx);
        case (idx)
            SCAN_UNITS: return sh_units;
            SCAN_TENS:  return sh_tens;
            default:    return sh_hundreds;
        endcase
    endfunction

    // Next: decimal increment; a blank digit carries as 10; saturate at 999
    task automatic channel_up();
        int u, t, h;
        u = int'(sh_units) + 1;
        t = int'(sh_tens);
        h = int'(sh_hundreds);
        if (u > 9) begin
            u = 0;
            t = t + 1;
            if (t > 9) begin
                t = 0;
                h = h + 1;
                if (h > 9) begin
                    u = 9;
                    t = 9;
                    h = 9;
                end
            end
        end
        sh_units    = digit_t'(u);
        sh_tens     = digit_t'(t);
        sh_hundreds = digit_t'(h);
    endtask

    // Previous: decimal decrement; saturate at 000
    task automatic channel_down();
        int u, t, h;
        u = int'(sh_units) - 1;
        t = int'(sh_tens);
        h = int'(sh_hundreds);
        if (u < 0) begin
            u = 9;
            t = t - 1;
            if (t < 0) begin
                t = 9;
                h = h - 1;
                if (h < 0) begin
                    u = 0;
                    t = 0;
                    h = 0;
                end
            end
        end
        sh_units    = digit_t'(u);
        sh_tens     = digit_t'(t);
        sh_hundreds = digit_t'(h);
    endtask

    // Shift a digit in from the right; the third digit closes the entry
    task automatic shift_in_digit(input digit_t key);
        case (sh_pos)
            POS_FIRST:
            begin
                sh_units       = key;
                sh_tens        = DIGIT_BLANK;
                sh_hundreds    = DIGIT_BLANK;
                sh_entry_ticks = ENTRY_TIMEOUT_W'(1);
                sh_pos         = POS_SECOND;
            end
            POS_SECOND:
            begin
                sh_tens        = sh_units;
                sh_units       = key;
                sh_entry_ticks = ENTRY_TIMEOUT_W'(1);
                sh_pos         = POS_LAST;
            end
            default:
            begin
                sh_hundreds    = sh_tens;
                sh_tens        = sh_units;
                sh_units       = key;
                sh_entry_ticks = '0;
                sh_pos         = POS_FIRST;
            end
        endcase
        sh_idle_ticks = SLEEP_TIMEOUT_W'(1);
    endtask

    // Advance the scan and both timers on a tick
    task automatic scan_tick();
        sh_scan = (sh_scan >= SCAN_LAST) ? SCAN_UNITS : scan_t'(sh_scan + 1);
        sh_segs = ~glyph_of(digit_at(sh_scan));
        if (sh_entry_ticks != 0) begin
            sh_entry_ticks = sh_entry_ticks + ENTRY_TIMEOUT_W'(1);
            if (sh_entry_ticks >= sh_entry_limit) begin
                sh_entry_ticks = '0;
                sh_pos         = POS_FIRST;
                sh_idle_ticks  = SLEEP_TIMEOUT_W'(1);
                entries_timed++;
            end
        end
        if (sh_idle_ticks != 0) begin
            if (sh_idle_ticks >= sh_sleep_limit) begin
                sh_asleep     = 1'b1;
                sh_idle_ticks = '0;
                sh_segs       = '0;
                sleeps_seen++;
            end else begin
                sh_idle_ticks = sh_idle_ticks + SLEEP_TIMEOUT_W'(1);
            end
        end
    endtask

    // Predict the display transaction caused by one input transaction
    task automatic predict_display(input key_item_t it, output display_t d);
        if (it.cmd == CMD_TICK) begin
            if (!sh_asleep)
                scan_tick();
        end else begin
            // Any key wakes the block, then acts as usual
            if (sh_asleep) begin
                sh_asleep     = 1'b0;
                sh_scan       = SCAN_UNITS;
                sh_idle_ticks = SLEEP_TIMEOUT_W'(1);
                wakes_seen++;
            end
            if (it.key == KEY_NEXT) begin
                channel_up();
                sh_idle_ticks = SLEEP_TIMEOUT_W'(1);
            end else if (it.key == KEY_PREV) begin
                channel_down();
                sh_idle_ticks = SLEEP_TIMEOUT_W'(1);
            end else if (it.key <= DIGIT_MAX) begin
                shift_in_digit(it.key);
            end
        end
        d.asleep   = sh_asleep;
        d.select   = sh_asleep ? '0 : SELECT_W'(3'b001 << sh_scan);
        d.segs     = sh_asleep ? '0 : sh_segs;
        d.units    = sh_units;
        d.tens     = sh_tens;
        d.hundreds = sh_hundreds;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("tb_top: mismatch at %0t on %s: got %0d, expected %0d",
                     $realtime, what, got, want);
    endtask

    task automatic check_display(input display_t got);
        display_t want;
        if (expected_disp.size() == 0) begin
            report_mismatch("display transaction with nothing pending", 1, 0);
        end else begin
            want = expected_disp.pop_front();
            if (got.select != want.select)
                report_mismatch("digit_select", int'(got.select), int'(want.select));
            if (got.segs != want.segs)
                report_mismatch("segment_drive", int'(got.segs), int'(want.segs));
            if (got.asleep != want.asleep)
                report_mismatch("asleep", int'(got.asleep), int'(want.asleep));
            if (got.units != want.units)
                report_mismatch("units", int'(got.units), int'(want.units));
            if (got.tens != want.tens)
                report_mismatch("tens", int'(got.tens), int'(want.tens));
            if (got.hundreds != want.hundreds)
                report_mismatch("hundreds", int'(got.hundreds), int'(want.hundreds));
        end
    endtask

    // ------------------------------------------------------------------
    // Rising edge: check results, predict accepted input, track config
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : edge_watch
        key_item_t taken;
        display_t  predicted;
        display_t  got;
        s_taken <= s_tvalid && s_tready;
        if (rst_n) begin
            // Check first: a result never belongs to the item taken this edge
            if (m_tvalid && m_tready) begin
                got.select   = m_tdata[2:0];
                got.segs     = m_tdata[10:3];
                got.units    = m_tdata[14:11];
                got.tens     = m_tdata[18:15];
                got.hundreds = m_tdata[22:19];
                got.asleep   = m_tuser;
                results_seen++;
                check_display(got);
            end
            if (s_tvalid && s_tready) begin
                taken.cmd = s_tuser;
                taken.key = s_tdata[3:0];
                predict_display(taken, predicted);
                expected_disp.push_back(predicted);
                items_taken++;
            end
            if (cfg_we) begin
                if (cfg_index == CFG_ENTRY_TIMEOUT)
                    sh_entry_limit = cfg_data[ENTRY_TIMEOUT_W-1:0];
                else if (cfg_index == CFG_SLEEP_TIMEOUT)
                    sh_sleep_limit = cfg_data[SLEEP_TIMEOUT_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: present the next pending item on the falling edge.
    // Hold the current item until its transaction completes.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_taken)) begin
            if (pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                next_item = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0000, next_item.key};
                s_tuser  <= next_item.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off in the
    // stall phase so that both internal registers fill and s_tready drops.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_phase && stall_cycles < STALL_LEN) begin
            m_tready     <= 1'b0;
            stall_cycles <= stall_cycles + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick();
        key_item_t it;
        it.cmd = CMD_TICK;
        it.key = digit_t'($urandom_range(0, 15));   // key field is don't-care on ticks
        pending.push_back(it);
    endtask

    task automatic push_key(input digit_t k);
        key_item_t it;
        it.cmd = CMD_KEY;
        it.key = k;
        pending.push_back(it);
    endtask

    // Append one burst of related items; return how many were queued
    task automatic push_burst(output int n);
        int kind, len;
        kind = $urandom_range(0, 99);
        n    = 0;
        if (kind < 45) begin
            // tick run: scan, entry close, sleep
            len = $urandom_range(1, tick_burst_max);
            repeat (len) push_tick();
            n = len;
        end else if (kind < 70) begin
            // digit entry of one to three digits, ticks in between
            len = $urandom_range(1, 3);
            repeat (len) begin
                push_key(digit_t'($urandom_range(0, 9)));
                n++;
                repeat ($urandom_range(0, 2)) begin
                    push_tick();
                    n++;
                end
            end
        end else if (kind < 85) begin
            // run of Next / Previous
            len = $urandom_range(1, 4);
            repeat (len) push_key($urandom_range(0, 1) ? KEY_NEXT : KEY_PREV);
            n = len;
        end else if (kind < 95) begin
            push_key(SPARE_KEYS[4 * $urandom_range(0, 3) +: 4]);
            n = 1;
        end else begin
            push_key(digit_t'($urandom_range(0, 15)));
            n = 1;
        end
    endtask

    // Block is idle once every item is out and every result is back
    task automatic wait_quiet();
        while (pending.size() != 0 || s_tvalid || expected_disp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int entry_to, input int sleep_to, input int n_items,
                             input int burst_max);
        int queued, n;
        wait_quiet();
        write_reg(CFG_ENTRY_TIMEOUT, entry_to);
        write_reg(CFG_SLEEP_TIMEOUT, sleep_to);
        tick_burst_max = burst_max;
        queued = 0;
        while (queued < n_items) begin
            push_burst(n);
            queued += n;
        end
    endtask

    task automatic set_gaps(input int send_pct, input int recv_pct);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Shadow state after reset: channel 321, default timeouts
        sh_units       = 4'd1;
        sh_tens        = 4'd2;
        sh_hundreds    = 4'd3;
        sh_pos         = POS_FIRST;
        sh_entry_ticks = '0;
        sh_idle_ticks  = SLEEP_TIMEOUT_W'(1);
        sh_scan        = SCAN_UNITS;
        sh_asleep      = 1'b0;
        sh_segs        = '0;
        sh_entry_limit = ENTRY_TIMEOUT_RST;
        sh_sleep_limit = SLEEP_TIMEOUT_RST;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: scan wrap from reset, lower saturation, blank carry on
        // Next with upper saturation, blank borrow on Previous, every digit
        // and every ignored code, under the reset timeouts.
        set_gaps(16, 78);
        repeat (3) push_tick();
        push_key(4'd0);
        push_key(4'd0);
        push_key(4'd0);
        push_key(KEY_PREV);      // 000 stays
        push_key(4'd9);          // 9 with blanks above
        push_key(KEY_NEXT);      // blank carries into 999
        push_key(KEY_NEXT);      // 999 stays
        push_key(4'd0);
        push_key(4'd5);
        push_key(4'd0);          // new entry, blanks above
        push_key(KEY_PREV);      // blank borrows as 9
        for (int k = 1; k <= 8; k++)
            if (k != 5)
                push_key(digit_t'(k));
        for (int i = 0; i < 4; i++)
            push_key(SPARE_KEYS[4 * i +: 4]);

        // Lowest legal timeouts: entry closes and sleep falls almost at once
        run_phase(2, 2, 200, 6);
        wait_quiet();
        set_gaps(78, 16);
        // Highest timeouts
        run_phase(1023, 4095, 200, 40);
        run_phase(9, 45, 400, 20);
        wait_quiet();
        set_gaps(0, 0);
        // Timeouts below the legal range
        run_phase(0, 1, 100, 4);
        wait_quiet();
        stall_phase = 1'b1;
        run_phase(17, 90, 400, 30);

        wait_quiet();
        repeat (8) @(posedge clk);
        if (expected_disp.size() != 0)
            report_mismatch("display transactions never delivered",
                            expected_disp.size(), 0);
        $display("tb_top: %0d input transactions, %0d display transactions checked",
                 items_taken, results_seen);
        $display("tb_top: %0d timed-out entries, %0d sleeps, %0d wake-ups, %0d errors",
                 entries_timed, sleeps_seen, wakes_seen, errors);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #400000;
        $display("tb_top: watchdog expired");
        $display("tb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cedc_pkg.sv
hw/rtl/cedc_digits.sv
hw/rtl/channel_entry_display_controller.sv
dv/tb_top.sv
